// ----- src/stack_machine_with_roll_defines.svh -----
// Assertion macros for the stack machine block.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef STACK_MACHINE_WITH_ROLL_DEFINES_SVH
`define STACK_MACHINE_WITH_ROLL_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SMR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SMR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/smr_pkg.sv -----
// Shared types and constants for the stack machine: command and status codes,
// microcode word layout and the microcode ROM. No dependencies.
package smr_pkg;

  localparam logic [2:0] MODE_PUSH  = 3'd0;
  localparam logic [2:0] MODE_POP   = 3'd1;
  localparam logic [2:0] MODE_SWAP  = 3'd2;
  localparam logic [2:0] MODE_ADD   = 3'd3;
  localparam logic [2:0] MODE_ROLL  = 3'd4;
  localparam logic [2:0] MODE_PRINT = 3'd5;

  localparam logic [1:0] ST_ENTRY = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_FULL, C_EMPTY, C_LT2, C_ROLL_BAD, C_LC_GT1
  } cond_t;
  typedef enum logic {A_TOP, A_PTR} asel_t;
  typedef enum logic [1:0] {W_CNT, W_PTR, W_PTR1} wasel_t;
  typedef enum logic [1:0] {D_PUSH, D_RDATA, D_A, D_SUM} wdsel_t;
  typedef enum logic [1:0] {CNT_KEEP, CNT_INC, CNT_DEC} cnt_op_t;
  typedef enum logic [1:0] {PTR_KEEP, PTR_CNT1, PTR_CNT2, PTR_DEC} ptr_op_t;
  typedef enum logic [2:0] {LC_KEEP, LC_ONE, LC_T, LC_CNT, LC_DEC} lc_op_t;
  typedef enum logic [1:0] {E_NONE, E_ENTRY, E_EMPTY, E_OVF} emit_t;

  typedef struct packed {
    cond_t   cond;    // branch to tgt when true
    upc_t    tgt;
    logic    fin;     // end of command when not branching
    logic    rd;
    asel_t   asel;
    logic    wr;
    wasel_t  wasel;
    wdsel_t  wdsel;
    logic    load_a;
    cnt_op_t cnt_op;
    ptr_op_t ptr_op;
    lc_op_t  lc_op;
    emit_t   emit;
  } uword_t;

  // Microcode addresses
  localparam upc_t U_END       = 5'd0;
  localparam upc_t U_PUSH0     = 5'd1;
  localparam upc_t U_PUSH1     = 5'd2;
  localparam upc_t U_PUSH_OVF  = 5'd3;
  localparam upc_t U_POP0      = 5'd4;
  localparam upc_t U_POP1      = 5'd5;
  localparam upc_t U_SWAP0     = 5'd6;
  localparam upc_t U_SWAP1     = 5'd7;
  localparam upc_t U_SWAP2     = 5'd8;
  localparam upc_t U_ADD0      = 5'd9;
  localparam upc_t U_ADD1      = 5'd10;
  localparam upc_t U_ADD2      = 5'd11;
  localparam upc_t U_ADD3      = 5'd12;
  localparam upc_t U_ROLL0     = 5'd13;
  localparam upc_t U_ROLL1     = 5'd14;
  localparam upc_t U_ROLL2     = 5'd15;
  localparam upc_t U_ROLL3     = 5'd16;
  localparam upc_t U_ROLL4     = 5'd17;
  localparam upc_t U_PRINT0    = 5'd18;
  localparam upc_t U_PRINT1    = 5'd19;
  localparam upc_t U_PRINT2    = 5'd20;
  localparam upc_t U_SINK1     = 5'd21;
  localparam upc_t U_SINK2     = 5'd22;
  localparam upc_t U_PRINT_NIL = 5'd23;
  localparam upc_t U_SINK0     = 5'd24;

  localparam uword_t UW_NOP = '{
    cond: C_NEVER, tgt: U_END, fin: 1'b0, rd: 1'b0, asel: A_TOP, wr: 1'b0,
    wasel: W_CNT, wdsel: D_PUSH, load_a: 1'b0, cnt_op: CNT_KEEP,
    ptr_op: PTR_KEEP, lc_op: LC_KEEP, emit: E_NONE
  };

  function automatic upc_t mode_entry(logic [2:0] mode);
    upc_t e;
    case (mode)
      MODE_PUSH:  e = U_PUSH0;
      MODE_POP:   e = U_POP0;
      MODE_SWAP:  e = U_SWAP0;
      MODE_ADD:   e = U_ADD0;
      MODE_ROLL:  e = U_ROLL0;
      MODE_PRINT: e = U_PRINT0;
      default:    e = U_END;
    endcase
    return e;
  endfunction

  function automatic uword_t uw_rom(upc_t a);
    uword_t w;
    w = UW_NOP;
    case (a)
      U_END: begin
        w.fin = 1'b1;
      end
      U_PUSH0: begin
        w.cond = C_FULL; w.tgt = U_PUSH_OVF;
      end
      U_PUSH1: begin
        w.wr = 1'b1; w.wasel = W_CNT; w.wdsel = D_PUSH;
        w.cnt_op = CNT_INC; w.fin = 1'b1;
      end
      U_PUSH_OVF: begin
        w.emit = E_OVF; w.fin = 1'b1;
      end
      U_POP0: begin
        w.cond = C_EMPTY; w.tgt = U_END;
      end
      U_POP1: begin
        w.cnt_op = CNT_DEC; w.fin = 1'b1;
      end
      U_SWAP0: begin
        w.cond = C_LT2; w.tgt = U_END;
      end
      U_SWAP1: begin
        w.rd = 1'b1; w.asel = A_TOP; w.ptr_op = PTR_CNT2; w.lc_op = LC_ONE;
      end
      U_SWAP2: begin
        w.load_a = 1'b1; w.rd = 1'b1; w.asel = A_PTR;
        w.cond = C_ALWAYS; w.tgt = U_SINK1;
      end
      U_ADD0: begin
        w.cond = C_LT2; w.tgt = U_END;
      end
      U_ADD1: begin
        w.rd = 1'b1; w.asel = A_TOP; w.ptr_op = PTR_CNT2;
      end
      U_ADD2: begin
        w.load_a = 1'b1; w.rd = 1'b1; w.asel = A_PTR;
      end
      U_ADD3: begin
        w.wr = 1'b1; w.wasel = W_PTR; w.wdsel = D_SUM;
        w.cnt_op = CNT_DEC; w.fin = 1'b1;
      end
      U_ROLL0: begin
        w.cond = C_EMPTY; w.tgt = U_END;
      end
      U_ROLL1: begin
        w.rd = 1'b1; w.asel = A_TOP; w.cnt_op = CNT_DEC;
      end
      U_ROLL2: begin
        w.cond = C_ROLL_BAD; w.tgt = U_END;
        w.lc_op = LC_T; w.ptr_op = PTR_CNT2;
      end
      U_ROLL3: begin
        w.rd = 1'b1; w.asel = A_TOP;
      end
      U_ROLL4: begin
        w.load_a = 1'b1; w.rd = 1'b1; w.asel = A_PTR;
        w.cond = C_ALWAYS; w.tgt = U_SINK1;
      end
      U_PRINT0: begin
        w.cond = C_EMPTY; w.tgt = U_PRINT_NIL;
        w.ptr_op = PTR_CNT1; w.lc_op = LC_CNT;
      end
      U_PRINT1: begin
        w.rd = 1'b1; w.asel = A_PTR;
      end
      U_PRINT2: begin
        w.emit = E_ENTRY; w.ptr_op = PTR_DEC; w.lc_op = LC_DEC;
        w.cond = C_LC_GT1; w.tgt = U_PRINT1; w.fin = 1'b1;
      end
      U_SINK1: begin
        w.wr = 1'b1; w.wasel = W_PTR1; w.wdsel = D_RDATA;
        w.ptr_op = PTR_DEC; w.lc_op = LC_DEC;
        w.cond = C_LC_GT1; w.tgt = U_SINK0;
      end
      U_SINK2: begin
        w.wr = 1'b1; w.wasel = W_PTR1; w.wdsel = D_A; w.fin = 1'b1;
      end
      U_PRINT_NIL: begin
        w.emit = E_EMPTY; w.fin = 1'b1;
      end
      U_SINK0: begin
        w.rd = 1'b1; w.asel = A_PTR; w.cond = C_ALWAYS; w.tgt = U_SINK1;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- src/smr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module smr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/stack_machine_with_roll.sv -----
// Stack machine with roll: top level. A bounded stack of 32-bit words driven
// by a microcoded sequencer. Uses smr_pkg, smr_ram and the assertion macros.
//
// - Input channel (in_valid/in_ready) takes one command item: in_mode
//   (push, pop, swap, add, roll, print) and in_push_value for push.
// - Output channel (out_valid/out_ready): a print emits every entry top to
//   bottom with out_last on the final one; a print of an empty stack and a
//   push onto a full stack each emit one status item. Others emit nothing.
// - One command at a time; in_ready is high whenever the sequencer is idle,
//   even while a result still sits in the output register.
// - Per command: a roll pops t (the popped depth) and moves entries when t is
//   valid, else it only pops; unused modes do nothing; a command that finds
//   too few entries ends without further steps. Per moved or printed entry:
//   one RAM read (registered data), then one write or emit.
// - The first print result passes the PRINT0 check and the PRINT1 RAM read
//   before the PRINT2 step emits it into the output register.
// - A stalled receiver holds the sequencer at its emit step; nothing is lost
//   or repeated, and the command resumes when out_ready returns.
// - Reset empties the stack (count to zero) and drops any pending result;
//   the stack RAM itself is not cleared.
`include "stack_machine_with_roll_defines.svh"

module stack_machine_with_roll #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [29:0]        in_push_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_stack_value,
  output logic [1:0]         out_status,
  output logic               out_last
);

  localparam int CW = $clog2(STACK_DEPTH + 1);  // entry count width
  localparam int AW = $clog2(STACK_DEPTH);      // stack address width

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t              state_r, state_nxt;
  smr_pkg::upc_t       pc_r, pc_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       lc_r, lc_nxt;       // remaining loop passes
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [31:0]         a_r, a_nxt;         // saved top / first operand
  logic [29:0]         pv_r, pv_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_value_r, out_value_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  smr_pkg::uword_t     uw;
  logic                cond_true;
  logic                emit_stall;
  logic                go;
  logic [AW-1:0]       top_addr, cnt1_addr, cnt2_addr;
  logic [31:0]         rdata;
  logic [31:0]         sum_w;
  logic [31:0]         t_m1;
  logic                roll_bad;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [31:0]         ram_wdata;

  assign uw        = smr_pkg::uw_rom(pc_r);
  assign top_addr  = AW'(cnt_r - CW'(1));
  assign cnt1_addr = top_addr;
  assign cnt2_addr = AW'(cnt_r - CW'(2));
  assign sum_w     = a_r + rdata;
  assign t_m1      = rdata - 32'd1;

  // Roll target is valid only for 2 <= t <= remaining count, t non-negative
  assign roll_bad = rdata[31] || (rdata < 32'd2) || (rdata > 32'(cnt_r));

  always_comb begin
    case (uw.cond)
      smr_pkg::C_NEVER:    cond_true = 1'b0;
      smr_pkg::C_ALWAYS:   cond_true = 1'b1;
      smr_pkg::C_FULL:     cond_true = (cnt_r >= CW'(STACK_DEPTH));
      smr_pkg::C_EMPTY:    cond_true = (cnt_r == '0);
      smr_pkg::C_LT2:      cond_true = (cnt_r < CW'(2));
      smr_pkg::C_ROLL_BAD: cond_true = roll_bad;
      smr_pkg::C_LC_GT1:   cond_true = (lc_r != CW'(1));
      default:             cond_true = 1'b0;
    endcase
  end

  // An emit step waits until the output register is free or being drained
  assign emit_stall = (uw.emit != smr_pkg::E_NONE) && out_valid_r && !out_ready;
  assign go         = (state_r == S_RUN) && !emit_stall;

  assign ram_re    = go && uw.rd;
  assign ram_raddr = (uw.asel == smr_pkg::A_TOP) ? top_addr : ptr_r;
  assign ram_we    = go && uw.wr;

  always_comb begin
    case (uw.wasel)
      smr_pkg::W_CNT:  ram_waddr = AW'(cnt_r);
      smr_pkg::W_PTR:  ram_waddr = ptr_r;
      smr_pkg::W_PTR1: ram_waddr = ptr_r + AW'(1);
      default:         ram_waddr = ptr_r;
    endcase
    case (uw.wdsel)
      smr_pkg::D_PUSH:  ram_wdata = {2'b00, pv_r};
      smr_pkg::D_RDATA: ram_wdata = rdata;
      smr_pkg::D_A:     ram_wdata = a_r;
      smr_pkg::D_SUM:   ram_wdata = sum_w;
      default:          ram_wdata = rdata;
    endcase
  end

  smr_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    cnt_nxt        = cnt_r;
    lc_nxt         = lc_r;
    ptr_nxt        = ptr_r;
    a_nxt          = a_r;
    pv_nxt         = pv_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    if (state_r == S_IDLE) begin
      if (in_valid) begin
        state_nxt = S_RUN;
        pc_nxt    = smr_pkg::mode_entry(in_mode);
        pv_nxt    = in_push_value;
      end
    end else if (go) begin
      // step sequencing
      if (cond_true) begin
        pc_nxt = uw.tgt;
      end else if (uw.fin) begin
        state_nxt = S_IDLE;
      end else begin
        pc_nxt = pc_r + smr_pkg::upc_t'(1);
      end

      if (uw.load_a) begin
        a_nxt = rdata;
      end

      case (uw.cnt_op)
        smr_pkg::CNT_INC: cnt_nxt = cnt_r + CW'(1);
        smr_pkg::CNT_DEC: cnt_nxt = cnt_r - CW'(1);
        default:          cnt_nxt = cnt_r;
      endcase

      case (uw.ptr_op)
        smr_pkg::PTR_CNT1: ptr_nxt = cnt1_addr;
        smr_pkg::PTR_CNT2: ptr_nxt = cnt2_addr;
        smr_pkg::PTR_DEC:  ptr_nxt = ptr_r - AW'(1);
        default:           ptr_nxt = ptr_r;
      endcase

      case (uw.lc_op)
        smr_pkg::LC_ONE: lc_nxt = CW'(1);
        smr_pkg::LC_T:   lc_nxt = t_m1[CW-1:0];
        smr_pkg::LC_CNT: lc_nxt = cnt_r;
        smr_pkg::LC_DEC: lc_nxt = lc_r - CW'(1);
        default:         lc_nxt = lc_r;
      endcase

      case (uw.emit)
        smr_pkg::E_ENTRY: begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rdata;
          out_status_nxt = smr_pkg::ST_ENTRY;
          out_last_nxt   = (lc_r == CW'(1));
        end
        smr_pkg::E_EMPTY: begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = smr_pkg::ST_EMPTY;
          out_last_nxt   = 1'b1;
        end
        smr_pkg::E_OVF: begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = smr_pkg::ST_OVF;
          out_last_nxt   = 1'b1;
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pc_r         <= pc_nxt;
    lc_r         <= lc_nxt;
    ptr_r        <= ptr_nxt;
    a_r          <= a_nxt;
    pv_r         <= pv_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_stack_value = out_value_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  `SMR_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(STACK_DEPTH), "entry count above depth")
  `SMR_ASSERT_NXT(a_idle_cnt, state_r == S_IDLE, $stable(cnt_r), "count moved while idle")
  `SMR_ASSERT_IMP(a_emit_run, $rose(out_valid_r), $past(state_r == S_RUN), "result outside run")
  `SMR_ASSERT_IMP(a_waddr_rng, ram_we, {1'b0, ram_waddr} < (AW+1)'(STACK_DEPTH), "bad write address")

endmodule
